// ----- rtl/chrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consistent-hash ring picker package
// Shared widths, depths and result codes of the ring picker.
// ----------------------------------------------------------------------------
package chrp_pkg;

  localparam int RING_DEPTH    = 4096;
  localparam int RING_AW       = $clog2(RING_DEPTH);
  localparam int CNT_W         = RING_AW + 1;
  localparam int MAX_ENDPOINTS = 256;
  localparam int EP_W          = $clog2(MAX_ENDPOINTS);
  localparam int HASH_W        = 64;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_STATE = 2'd1,
    KIND_PICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_CONNECTING = 2'd1,
    ST_READY      = 2'd2,
    ST_FAILURE    = 2'd3
  } conn_t;

  typedef enum logic [2:0] {
    V_PICKED    = 3'd0,
    V_QUEUE     = 3'd1,
    V_FAIL_CONN = 3'd2,
    V_FAIL_HASH = 3'd3,
    V_WRITE_ACK = 3'd4
  } verdict_t;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

endpackage

// ----- rtl/consistent_hash_ring_picker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consistent-hash ring picker
// Ketama lookup over a sorted ring held in block memory, with endpoint states.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_valid/in_ready channel; each yields exactly one
//   result on out_valid/out_ready. A ring entry write and an unknown kind go
//   straight to the response state; a state update first reads and then
//   writes the endpoint state. A pick runs a binary search over the ring,
//   each probe a ring read then a compare (at most about log2(ring size)+1
//   probes), then walks the ring, reading owner, then endpoint state, then
//   deciding, entry by entry until a usable endpoint is found, bounded by the
//   ring size. The search probe waits on the registered read of the ring
//   memory, and the walk on the chained reads of ring owner and endpoint state.
//   The block handles one request at a time. A finished result sits in an
//   output register, so the next request is taken while it waits; if the
//   receiver stalls a second finished result waits in its final state.
//   Reset clears endpoint state valid bits (all read idle), the connecting
//   count and mode, and sets ring size to one. Ring memory is not cleared.
//   Configuration writes are accepted at any time but are meant for idle.
// ----------------------------------------------------------------------------
module consistent_hash_ring_picker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [12:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [chrp_pkg::RING_AW-1:0]   position,
  input  logic [chrp_pkg::HASH_W-1:0]    hash_value,
  input  logic [chrp_pkg::EP_W-1:0]      endpoint,
  input  logic [1:0]                     conn_state,
  input  logic                           hash_present,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     verdict,
  output logic [chrp_pkg::EP_W-1:0]      chosen_endpoint,
  output logic                           connect_request,
  output logic [chrp_pkg::EP_W-1:0]      connect_endpoint,
  output logic [chrp_pkg::RING_AW-1:0]   start_index,
  output logic [chrp_pkg::EP_W-1:0]      failed_endpoint
);
  import chrp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_WALK_OWN, S_WALK_ST, S_WALK_DEC,
    S_UPD_RD, S_UPD_WR, S_RESP
  } state_t;

  localparam int ENT_W = HASH_W + EP_W;

  // Configuration registers.
  logic             mode;
  logic [12:0]      ring_used;
  logic [CNT_W-1:0] ring_n;

  always_comb begin
    if (ring_used == '0) begin
      ring_n = CNT_W'(1);
    end else if (ring_used > 13'(RING_DEPTH)) begin
      ring_n = CNT_W'(RING_DEPTH);
    end else begin
      ring_n = CNT_W'(ring_used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      ring_used <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode      <= cfg_data[0];
        CFG_SIZE: ring_used <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Ring memory: hash and owner in one word, one write and two read ports.
  logic [ENT_W-1:0]   ring_mem [RING_DEPTH];
  logic               ring_we;
  logic [RING_AW-1:0] ring_wa, ring_ra, ring_rb;
  logic [ENT_W-1:0]   ring_wd, ring_qa, ring_qb;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_qa <= ring_mem[ring_ra];
    ring_qb <= ring_mem[ring_rb];
  end

  // Endpoint state memory with a valid bit per entry; invalid reads as idle.
  logic [1:0]         ep_mem [MAX_ENDPOINTS];
  logic [MAX_ENDPOINTS-1:0] ep_vld;
  logic               ep_we;
  logic [EP_W-1:0]    ep_wa, ep_ra;
  logic [1:0]         ep_wd, ep_q;
  logic               ep_vq;
  logic [1:0]         ep_state;

  always_ff @(posedge clk) begin
    if (ep_we) begin
      ep_mem[ep_wa] <= ep_wd;
    end
    ep_q  <= ep_mem[ep_ra];
    ep_vq <= ep_vld[ep_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ep_vld <= '0;
    end else if (ep_we) begin
      ep_vld[ep_wa] <= 1'b1;
    end
  end

  assign ep_state = ep_vq ? ep_q : ST_IDLE;

  // Control and working registers.
  state_t                state;
  logic [8:0]            conn_count;
  logic [HASH_W-1:0]     req_hash;
  logic                  random_hash;
  logic                  requested;
  logic signed [13:0]    lo, hi;
  logic [CNT_W-1:0]      mid;
  logic [RING_AW-1:0]    idx;
  logic [CNT_W-1:0]      step;
  logic [EP_W-1:0]       owner;
  logic [EP_W-1:0]       first_owner;
  logic [EP_W-1:0]       upd_ep;
  logic [1:0]            upd_cs;

  logic [2:0]            r_verdict;
  logic [EP_W-1:0]       r_chosen, r_cep, r_failed;
  logic                  r_creq;
  logic [RING_AW-1:0]    r_start;

  // Search arithmetic.
  logic signed [14:0]    bound_sum;
  logic [CNT_W-1:0]      mid_calc;
  logic [HASH_W-1:0]     v_hash, v1_hash;
  logic signed [13:0]    lo_up, hi_dn;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      step_inc;

  assign bound_sum = 15'(lo) + 15'(hi);
  assign mid_calc  = CNT_W'(bound_sum >>> 1);
  assign v_hash    = ring_qa[ENT_W-1:EP_W];
  assign v1_hash   = (mid == '0) ? '0 : ring_qb[ENT_W-1:EP_W];
  assign lo_up     = $signed({1'b0, mid}) + 14'sd1;
  assign hi_dn     = $signed({1'b0, mid}) - 14'sd1;
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign step_inc  = step + CNT_W'(1);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ring_we = 1'b0;
    ring_wa = position;
    ring_wd = {hash_value, endpoint};
    ring_ra = idx;
    ring_rb = idx;
    if (state == S_IDLE && in_valid && kind == KIND_WRITE) begin
      ring_we = 1'b1;
    end
    if (state == S_SRCH_RD) begin
      ring_ra = mid_calc[RING_AW-1:0];
      ring_rb = mid_calc[RING_AW-1:0] - RING_AW'(1);
    end
  end

  always_comb begin
    ep_ra = endpoint;
    if (state == S_UPD_RD) begin
      ep_ra = upd_ep;
    end
    if (state == S_WALK_ST) begin
      ep_ra = ring_qa[EP_W-1:0];
    end
    ep_we = (state == S_UPD_WR);
    ep_wa = upd_ep;
    ep_wd = upd_cs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      conn_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // In the response state the output register is refilled instead.
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_verdict   <= V_WRITE_ACK;
            r_chosen    <= '0;
            r_creq      <= 1'b0;
            r_cep       <= '0;
            r_start     <= '0;
            r_failed    <= '0;
            req_hash    <= hash_value;
            random_hash <= !hash_present;
            requested   <= (conn_count != '0);
            upd_ep      <= endpoint;
            upd_cs      <= conn_state;
            lo          <= '0;
            hi          <= $signed({1'b0, ring_n});
            step        <= '0;
            case (kind)
              KIND_STATE: state <= S_UPD_RD;
              KIND_PICK: begin
                if (!hash_present && !mode) begin
                  r_verdict <= V_FAIL_HASH;
                  state     <= S_RESP;
                end else begin
                  state <= S_SRCH_RD;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          if (ep_state == ST_CONNECTING && conn_count != '0) begin
            conn_count <= (upd_cs == ST_CONNECTING) ? conn_count : conn_count - 9'd1;
          end else if (upd_cs == ST_CONNECTING) begin
            conn_count <= conn_count + 9'd1;
          end
          state <= S_RESP;
        end
        S_SRCH_RD: begin
          mid <= mid_calc;
          if (mid_calc == ring_n) begin
            idx   <= '0;
            state <= S_WALK_OWN;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (req_hash <= v_hash && req_hash > v1_hash) begin
            r_start <= mid[RING_AW-1:0];
            idx     <= mid[RING_AW-1:0];
            state   <= S_WALK_OWN;
          end else if (v_hash < req_hash) begin
            lo <= lo_up;
            if (lo_up > hi) begin
              idx   <= '0;
              state <= S_WALK_OWN;
            end else begin
              state <= S_SRCH_RD;
            end
          end else begin
            hi <= hi_dn;
            if (lo > hi_dn) begin
              idx   <= '0;
              state <= S_WALK_OWN;
            end else begin
              state <= S_SRCH_RD;
            end
          end
        end
        S_WALK_OWN: state <= S_WALK_ST;
        S_WALK_ST: begin
          owner <= ring_qa[EP_W-1:0];
          if (step == '0) begin
            first_owner <= ring_qa[EP_W-1:0];
          end
          state <= S_WALK_DEC;
        end
        S_WALK_DEC: begin
          idx   <= (idx_inc >= ring_n) ? '0 : idx_inc[RING_AW-1:0];
          step  <= step_inc;
          state <= S_WALK_OWN;
          if (ep_state == ST_READY) begin
            r_verdict <= V_PICKED;
            r_chosen  <= owner;
            state     <= S_RESP;
          end else if (!random_hash && ep_state == ST_IDLE) begin
            r_verdict <= V_QUEUE;
            r_creq    <= 1'b1;
            r_cep     <= owner;
            state     <= S_RESP;
          end else if (!random_hash && ep_state == ST_CONNECTING) begin
            r_verdict <= V_QUEUE;
            state     <= S_RESP;
          end else begin
            if (random_hash && !requested && ep_state == ST_IDLE) begin
              r_creq    <= 1'b1;
              r_cep     <= owner;
              requested <= 1'b1;
            end
            if (step_inc == ring_n) begin
              state <= S_RESP;
              if (random_hash && (requested || ep_state == ST_IDLE)) begin
                r_verdict <= V_QUEUE;
              end else begin
                r_verdict <= V_FAIL_CONN;
                r_failed  <= first_owner;
              end
            end
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            verdict          <= r_verdict;
            chosen_endpoint  <= r_chosen;
            connect_request  <= r_creq;
            connect_endpoint <= r_cep;
            start_index      <= r_start;
            failed_endpoint  <= r_failed;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The count of connecting endpoints can never pass the number of endpoints.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    conn_count <= 9'(MAX_ENDPOINTS))
    else $error("connecting count out of range");

  // Only a pick finds a ready endpoint.
  a_chosen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != V_PICKED |-> chosen_endpoint == '0)
    else $error("chosen endpoint set without a pick");

  // Acknowledged writes carry no connection request.
  a_ack_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == V_WRITE_ACK |-> !connect_request && start_index == '0)
    else $error("write acknowledgement carries pick fields");

  // A request taken keeps the input closed in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule
